[sv/cdiv_pkg.sv]
`default_nettype none

package cdiv_pkg;

    // operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_UDIV8  = 2'd0,
        OP_IDIV8  = 2'd1,
        OP_UDIV16 = 2'd2,
        OP_IDIV16 = 2'd3
    } op_t;

    localparam int unsigned QUEUE_DEPTH = 2;

    // one restoring step per quotient bit, quotient is at most 16 bits wide
    localparam int unsigned DIV_STEPS = 16;

    localparam logic [15:0] BYTE_Q_MAX  = 16'h00ff;
    localparam logic [15:0] BYTE_Q_LIM  = 16'h0080;
    localparam logic [15:0] WORD_Q_LIM  = 16'h8000;

    typedef struct packed {
        logic word;
        logic sgn;
        logic neg_dvd;
        logic neg_dvs;
        logic err;
    } ctl_t;

    // classified item handed from front to back
    typedef struct packed {
        ctl_t        ctl;
        logic [31:0] mag_dvd;
        logic [15:0] mag_dvs;
    } item_t;

endpackage

`default_nettype wire

[sv/cdiv_front.sv]
`default_nettype none

module cdiv_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     in_op,
    input  wire logic [31:0]    in_dvd,
    input  wire logic [15:0]    in_dvs,
    output logic                out_valid,
    input  wire logic           out_ready,
    output cdiv_pkg::item_t     out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [1:0]           op_reg;
    logic [31:0]          dvd_reg;
    logic [15:0]          dvs_reg;
    logic                 word;
    logic                 sgn;
    logic                 na;
    logic                 nb;
    logic [31:0]          dvd_neg;
    logic [15:0]          dvs_neg;
    logic [31:0]          mag_a;
    logic [15:0]          mag_b;
    cdiv_pkg::op_t        op;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            op_reg  <= in_op;
            dvd_reg <= in_dvd;
            dvs_reg <= in_dvs;
        end
    end

    // decode mode
    always_comb begin
        op = cdiv_pkg::op_t'(op_reg);
        unique case (op)
            cdiv_pkg::OP_UDIV8: begin
                word = 1'b0;
                sgn  = 1'b0;
            end
            cdiv_pkg::OP_IDIV8: begin
                word = 1'b0;
                sgn  = 1'b1;
            end
            cdiv_pkg::OP_UDIV16: begin
                word = 1'b1;
                sgn  = 1'b0;
            end
            cdiv_pkg::OP_IDIV16: begin
                word = 1'b1;
                sgn  = 1'b1;
            end
            default: begin
                word = 1'b0;
                sgn  = 1'b0;
            end
        endcase
    end

    // magnitudes; low bits of the wide negate serve the byte case too
    always_comb begin
        na      = sgn && (word ? dvd_reg[31] : dvd_reg[15]);
        nb      = sgn && (word ? dvs_reg[15] : dvs_reg[7]);
        dvd_neg = ~dvd_reg + 32'd1;
        dvs_neg = ~dvs_reg + 16'd1;
        if (word) begin
            mag_a = na ? dvd_neg : dvd_reg;
            mag_b = nb ? dvs_neg : dvs_reg;
        end else begin
            mag_a = {16'h0000, (na ? dvd_neg[15:0] : dvd_reg[15:0])};
            mag_b = {8'h00, (nb ? dvs_neg[7:0] : dvs_reg[7:0])};
        end
    end

    // zero divisor, or a quotient of 17 bits or more
    always_comb begin
        out_item.ctl.word    = word;
        out_item.ctl.sgn     = sgn;
        out_item.ctl.neg_dvd = na;
        out_item.ctl.neg_dvs = nb;
        out_item.ctl.err     = (mag_b == 16'h0000) || (mag_a[31:16] >= mag_b);
        out_item.mag_dvd     = mag_a;
        out_item.mag_dvs     = mag_b;
    end

endmodule

`default_nettype wire

[sv/cdiv_queue.sv]
`default_nettype none

module cdiv_queue #(
    parameter int unsigned DEPTH = cdiv_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire cdiv_pkg::item_t wr_item,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output cdiv_pkg::item_t      rd_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cdiv_pkg::item_t entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[sv/cdiv_back.sv]
`default_nettype none

module cdiv_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cdiv_pkg::item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [15:0]          out_quot,
    output logic [15:0]          out_rem,
    output logic                 out_err
);

    localparam int unsigned STEPS = cdiv_pkg::DIV_STEPS;

    // stage k holds {partial remainder, unused dividend bits, quotient bits}
    logic                 valid_reg [STEPS+1];
    logic [31:0]          acc_reg   [STEPS+1];
    logic [31:0]          acc_next  [STEPS+1];
    logic [15:0]          dvs_reg   [STEPS+1];
    cdiv_pkg::ctl_t       ctl_reg   [STEPS+1];

    logic                 adv;
    logic                 o_valid_reg;
    logic [15:0]          o_quot_reg;
    logic [15:0]          o_quot_next;
    logic [15:0]          o_rem_reg;
    logic [15:0]          o_rem_next;
    logic                 o_err_reg;
    logic                 o_err_next;

    logic [15:0]          q_mag;
    logic [15:0]          r_mag;
    logic [15:0]          q_neg;
    logic [15:0]          r_neg;
    logic [15:0]          q_lim;
    logic                 nq;
    logic                 range_err;
    cdiv_pkg::ctl_t       fin_ctl;

    // whole pipe moves when the output register is free or being drained
    assign adv       = !o_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = o_valid_reg;
    assign out_quot  = o_quot_reg;
    assign out_rem   = o_rem_reg;
    assign out_err   = o_err_reg;

    assign acc_next[0] = in_item.mag_dvd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg[0] <= acc_next[0];
            dvs_reg[0] <= in_item.mag_dvs;
            ctl_reg[0] <= in_item.ctl;
        end
    end

    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        logic [16:0] top;
        logic [15:0] diff;
        logic        ge;

        // when the subtract is taken the difference is below the divisor
        always_comb begin
            top  = acc_reg[k-1][31:15];
            diff = top[15:0] - dvs_reg[k-1];
            ge   = (top >= {1'b0, dvs_reg[k-1]});
            acc_next[k] = ge ? {diff,      acc_reg[k-1][14:0], 1'b1}
                             : {top[15:0], acc_reg[k-1][14:0], 1'b0};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                acc_reg[k] <= acc_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // range check and sign fix-up
    always_comb begin
        fin_ctl = ctl_reg[STEPS];
        q_mag   = acc_reg[STEPS][15:0];
        r_mag   = acc_reg[STEPS][31:16];
        q_neg   = ~q_mag + 16'd1;
        r_neg   = ~r_mag + 16'd1;
        q_lim   = fin_ctl.word ? cdiv_pkg::WORD_Q_LIM : cdiv_pkg::BYTE_Q_LIM;
        nq      = (fin_ctl.neg_dvd != fin_ctl.neg_dvs) && (q_mag != 16'h0000);
        if (fin_ctl.sgn) begin
            range_err = nq ? (q_mag > q_lim) : (q_mag >= q_lim);
        end else begin
            range_err = !fin_ctl.word && (q_mag > cdiv_pkg::BYTE_Q_MAX);
        end
        o_err_next  = fin_ctl.err || range_err;
        o_quot_next = nq ? q_neg : q_mag;
        o_rem_next  = fin_ctl.neg_dvd ? r_neg : r_mag;
        if (!fin_ctl.word) begin
            o_quot_next = {8'h00, o_quot_next[7:0]};
            o_rem_next  = {8'h00, o_rem_next[7:0]};
        end
        if (o_err_next) begin
            o_quot_next = 16'h0000;
            o_rem_next  = 16'h0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv) begin
            o_valid_reg <= valid_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            o_quot_reg <= o_quot_next;
            o_rem_reg  <= o_rem_next;
            o_err_reg  <= o_err_next;
        end
    end

endmodule

`default_nettype wire

[sv/cpu_div_idiv_unit.sv]
`default_nettype none

// Divide unit, 8- and 16-bit, signed and unsigned. One division is taken per
// cycle while the output is not stalled. A division passes the input register,
// the queue, the launch stage, one restoring step per quotient bit (16 stages,
// each a 16-bit subtract and a 17-bit compare) and the output register. Division by
// zero and a quotient out of range both return zero quotient and remainder
// with divide_error set on m_tuser. Results leave in transfer order.

module cpu_div_idiv_unit #(
    parameter int unsigned QUEUE_DEPTH = cdiv_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // dividend [31:0], divisor [47:32]
    input  wire logic [1:0]  s_tuser,   // operation [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // quotient [15:0], remainder [31:16]
    output logic [0:0]       m_tuser    // divide_error [0]
);

    logic            fr_valid;
    logic            fr_ready;
    cdiv_pkg::item_t fr_item;
    logic            bk_valid;
    logic            bk_ready;
    cdiv_pkg::item_t bk_item;
    logic [15:0]     quot;
    logic [15:0]     rem;
    logic            err;

    cdiv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_dvd    (s_tdata[31:0]),
        .in_dvs    (s_tdata[47:32]),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    cdiv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_item  (bk_item)
    );

    cdiv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_item   (bk_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_quot  (quot),
        .out_rem   (rem),
        .out_err   (err)
    );

    assign m_tdata = {rem, quot};
    assign m_tuser = err;

endmodule

`default_nettype wire

[sv/cdiv_checker.sv]
`default_nettype none

module cdiv_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [47:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a waiting transfer keeps its operands
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input changed while waiting");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an error result carries zero quotient and remainder
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'h0)
        else $error("error result with nonzero data");

    // after a reset cycle no result is out and the input is ready
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // the first transfer after reset cannot reach the output at once
    a_no_early: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !m_tvalid)
        else $error("result too early after reset");

endmodule

bind cpu_div_idiv_unit cdiv_checker u_cdiv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/tb_cpu_div_idiv_unit.sv]
`timescale 1ns / 100ps

typedef struct {
    logic [15:0] quot;
    logic [15:0] rem;
    logic        err;
} div_result_t;

class div_checker;
    div_result_t pending_qr[$];
    int unsigned n_fail;

    function new();
        n_fail = 0;
    endfunction

    // x86 style divide: truncate toward zero, remainder follows the dividend
    function div_result_t divide_op(cdiv_pkg::op_t op, logic [31:0] dvd_in,
                                    logic [15:0] dvs_in);
        logic        wide, sgn, neg_a, neg_b, neg_q, over;
        logic [31:0] dvd;
        logic [15:0] dvs;
        logic [63:0] a, b, qm, rm, lim, mask, q, r;
        div_result_t res;
        wide = (op == cdiv_pkg::OP_UDIV16) || (op == cdiv_pkg::OP_IDIV16);
        sgn  = (op == cdiv_pkg::OP_IDIV8) || (op == cdiv_pkg::OP_IDIV16);
        dvd  = wide ? dvd_in : {16'h0, dvd_in[15:0]};
        dvs  = wide ? dvs_in : {8'h0, dvs_in[7:0]};
        mask = wide ? 64'hffff : 64'hff;
        lim  = wide ? 64'h8000 : 64'h80;
        res.quot = '0;
        res.rem  = '0;
        res.err  = 1'b1;
        if (dvs == 16'h0)
            return res;
        neg_a = 1'b0;
        neg_b = 1'b0;
        if (!sgn) begin
            a = {32'h0, dvd};
            b = {48'h0, dvs};
        end else if (wide) begin
            neg_a = dvd[31];
            neg_b = dvs[15];
            a = neg_a ? {32'h0, -dvd} : {32'h0, dvd};
            b = neg_b ? {48'h0, -dvs} : {48'h0, dvs};
        end else begin
            neg_a = dvd[15];
            neg_b = dvs[7];
            a = neg_a ? 64'h10000 - dvd : {32'h0, dvd};
            b = neg_b ? 64'h100 - dvs : {48'h0, dvs};
        end
        qm = a / b;
        rm = a % b;
        neg_q = (neg_a != neg_b) && (qm != 0);
        if (!sgn)
            over = qm > mask;
        else
            over = neg_q ? (qm > lim) : (qm > lim - 1);
        if (over)
            return res;
        q = neg_q ? -qm : qm;
        r = (neg_a && rm != 0) ? -rm : rm;
        res.quot = q[15:0] & mask[15:0];
        res.rem  = r[15:0] & mask[15:0];
        res.err  = 1'b0;
        return res;
    endfunction

    function void note_division(cdiv_pkg::op_t op, logic [31:0] dvd, logic [15:0] dvs);
        pending_qr.push_back(divide_op(op, dvd, dvs));
    endfunction

    function void check_division(logic [15:0] quot, logic [15:0] rem, logic err);
        div_result_t exp_r;
        if (pending_qr.size() == 0) begin
            $error("result with no division pending: quotient %h remainder %h error %b",
                   quot, rem, err);
            n_fail++;
            return;
        end
        exp_r = pending_qr.pop_front();
        if (quot !== exp_r.quot) begin
            $error("quotient: expected %h, actual %h", exp_r.quot, quot);
            n_fail++;
        end
        if (rem !== exp_r.rem) begin
            $error("remainder: expected %h, actual %h", exp_r.rem, rem);
            n_fail++;
        end
        if (err !== exp_r.err) begin
            $error("divide_error: expected %b, actual %b", exp_r.err, err);
            n_fail++;
        end
    endfunction

    function int unsigned pending();
        return pending_qr.size();
    endfunction
endclass

module tb_cpu_div_idiv_unit;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = cdiv_pkg::OP_UDIV8;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    div_checker  chk;
    int unsigned n_results = 0;

    cpu_div_idiv_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // offer one division and wait for its transfer
    task automatic send_div(input cdiv_pkg::op_t op, input logic [31:0] dvd,
                            input logic [15:0] dvs, input int unsigned max_gap);
        int unsigned gap;
        logic        hs;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {dvs, dvd};
        do begin
            @(negedge aclk);
            hs = s_tready;
            @(posedge aclk);
        end while (!hs);
        chk.note_division(op, dvd, dvs);
    endtask

    task automatic pick_corner(output logic [31:0] dvd, output logic [15:0] dvs);
        case ($urandom_range(0, 7))
            0: dvd = 32'h0000_0000;
            1: dvd = 32'h0000_0001;
            2: dvd = 32'h7fff_ffff;
            3: dvd = 32'h8000_0000;
            4: dvd = 32'hffff_ffff;
            5: dvd = 32'h0000_8000;
            6: dvd = 32'hffff_8000;
            default: dvd = 32'h0000_7fff;
        endcase
        case ($urandom_range(0, 7))
            0: dvs = 16'h0001;
            1: dvs = 16'hffff;
            2: dvs = 16'h8000;
            3: dvs = 16'h7fff;
            4: dvs = 16'h0080;
            5: dvs = 16'h00ff;
            6: dvs = 16'h007f;
            default: dvs = 16'hff80;
        endcase
    endtask

    // mostly divisions whose quotient fits, built from divisor, quotient and remainder
    task automatic gen_div(output cdiv_pkg::op_t op, output logic [31:0] dvd,
                           output logic [15:0] dvs);
        int unsigned kind;
        logic        wide, sgn, na, nb;
        logic [31:0] amag, bmag, qmag, rmag;
        kind = $urandom_range(0, 99);
        op   = cdiv_pkg::op_t'($urandom_range(0, 3));
        wide = (op == cdiv_pkg::OP_UDIV16) || (op == cdiv_pkg::OP_IDIV16);
        sgn  = (op == cdiv_pkg::OP_IDIV8) || (op == cdiv_pkg::OP_IDIV16);
        dvd  = $urandom;
        dvs  = 16'($urandom);
        if (kind < 10) begin
            if (wide)
                dvs = 16'h0;
            else
                dvs[7:0] = 8'h0;
        end else if (kind < 30) begin
            // raw noise, mostly out of range in word modes
        end else if (kind < 42) begin
            pick_corner(dvd, dvs);
        end else begin
            if (sgn) begin
                bmag = $urandom_range(1, wide ? 32768 : 128);
                qmag = $urandom_range(0, wide ? 32768 : 128);
            end else begin
                bmag = $urandom_range(1, wide ? 65535 : 255);
                qmag = $urandom_range(0, wide ? 65535 : 255);
            end
            rmag = $urandom_range(0, bmag - 1);
            amag = qmag * bmag + rmag;
            na   = sgn && $urandom_range(0, 1);
            nb   = sgn && $urandom_range(0, 1);
            if (wide) begin
                dvd = na ? -amag : amag;
                dvs = nb ? -bmag[15:0] : bmag[15:0];
            end else begin
                dvd[15:0] = na ? -amag[15:0] : amag[15:0];
                dvs[7:0]  = nb ? -bmag[7:0] : bmag[7:0];
            end
        end
    endtask

    // result side: random stalls, one long hold so the pipe backs up, and a run with no stalls
    initial begin
        int unsigned hold;
        logic        hs;
        logic [31:0] data;
        logic        err;
        wait (aresetn === 1'b1);
        forever begin
            if (n_results == 100)
                hold = 150;
            else if (n_results >= 400 && n_results < 500)
                hold = 0;
            else
                hold = $urandom_range(0, 5);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                hs   = m_tvalid;
                data = m_tdata;
                err  = m_tuser[0];
                @(posedge aclk);
            end while (!hs);
            chk.check_division(data[15:0], data[31:16], err);
            n_results++;
        end
    end

    initial begin
        cdiv_pkg::op_t op;
        logic [31:0]   dvd;
        logic [15:0]   dvs;
        int unsigned   spin;
        chk = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte unsigned: zero divisor with high bits set, range edges, ignored bits
        send_div(cdiv_pkg::OP_UDIV8, 32'h0000_ffff, 16'hab00, 5);
        send_div(cdiv_pkg::OP_UDIV8, 32'h0000_00fe, 16'h0001, 5);
        send_div(cdiv_pkg::OP_UDIV8, 32'h0000_0100, 16'h0001, 5);
        send_div(cdiv_pkg::OP_UDIV8, 32'h0000_ffff, 16'h00ff, 5);
        send_div(cdiv_pkg::OP_UDIV8, 32'h0000_feff, 16'h00ff, 5);
        send_div(cdiv_pkg::OP_UDIV8, 32'habcd_1234, 16'hff12, 5);
        // byte signed: most negative by minus one, -128 quotient, sign of remainder
        send_div(cdiv_pkg::OP_IDIV8, 32'h0000_8000, 16'h00ff, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'h0000_ff80, 16'h0001, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'h0000_0080, 16'h0001, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'hffff_fff9, 16'hff02, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'h0000_0007, 16'h00fe, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'h0000_7fff, 16'h0080, 5);
        send_div(cdiv_pkg::OP_IDIV8, 32'h1234_5678, 16'h0000, 5);
        // word unsigned
        send_div(cdiv_pkg::OP_UDIV16, 32'hffff_ffff, 16'hffff, 5);
        send_div(cdiv_pkg::OP_UDIV16, 32'hfffe_ffff, 16'hffff, 5);
        send_div(cdiv_pkg::OP_UDIV16, 32'hffff_ffff, 16'h0000, 5);
        send_div(cdiv_pkg::OP_UDIV16, 32'h0000_0000, 16'hffff, 5);
        // word signed: -2^31 by -1, -32768 quotient, overflow on both sides
        send_div(cdiv_pkg::OP_IDIV16, 32'h8000_0000, 16'hffff, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'hffff_8000, 16'h0001, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'h0000_8000, 16'h0001, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'hffff_fff9, 16'h0002, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'h7fff_ffff, 16'h8000, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'h3fff_8000, 16'h8000, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'h4000_0000, 16'h8000, 5);
        send_div(cdiv_pkg::OP_IDIV16, 32'h0000_0005, 16'h0000, 5);

        for (int i = 0; i < 800; i++) begin
            gen_div(op, dvd, dvs);
            send_div(op, dvd, dvs, (i >= 200 && i < 300) ? 0 : 5);
        end
        s_tvalid <= 1'b0;

        spin = 0;
        while (chk.pending() != 0 && spin < 20000) begin
            @(posedge aclk);
            spin++;
        end
        if (chk.pending() != 0) begin
            $error("%0d results never arrived", chk.pending());
            $display("status: fail");
        end else begin
            repeat (40) @(posedge aclk);
            if (chk.n_fail == 0)
                $display("status: pass");
            else
                $display("status: fail");
        end
        $finish;
    end

endmodule
